// ===== rtl/aes128_kx_pkg.sv =====
// shared types, constants and the s-box for aes-128 key expansion
package aes128_kx_pkg;

  // number of the final round key
  localparam logic [3:0] LAST_ROUND = 4'd10;

  // first round constant and the gf(2^8) reduction term
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  // input request: key bytes 0..7 low, 8..15 high, byte 0 in bits 7:0
  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } kx_in_t;

  // one round key result
  typedef struct packed {
    logic [3:0]  round_index;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic        last_round;
  } kx_out_t;

  // aes forward s-box
  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // s-box applied to each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] v);
    sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

// ===== rtl/aes128_key_expansion_unit.sv =====
// aes-128 key expansion: one key in, eleven round keys out through one shared round unit
//
// A key request is taken when in_valid and in_ready are high; round keys 0 to 10 then
// follow on the output channel, one result per cycle while out_ready stays high, with
// last_round set on round 10. One round unit (rotword, four s-box lookups, rcon and
// the xor chain across the four columns) is reused for every round, so a key occupies
// the block for eleven output transfers, and in_ready returns the cycle after round 10
// is taken, so no new key is accepted before the last one is done. The current round key
// sits in a register that is held under back-pressure. layout_mode is sampled when each
// result is shown, so it should only be written while in_ready is high.
module aes128_key_expansion_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  aes128_kx_pkg::kx_in_t   in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output aes128_kx_pkg::kx_out_t  out_item,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t      state;
  logic        layout_mode;
  logic [3:0]  round;
  logic [7:0]  rcon;
  logic [31:0] col [0:3];

  logic        in_fire;
  logic        out_fire;
  logic [31:0] temp_word;
  logic [31:0] col_next [0:3];
  logic [31:0] row [0:3];

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_RUN);
  assign in_fire   = in_valid & in_ready;
  assign out_fire  = out_valid & out_ready;

  // shared round unit: rotword, subword, rcon, then the column xor chain
  always_comb begin
    temp_word   = aes128_kx_pkg::sub_word({col[3][7:0], col[3][31:8]}) ^ {24'd0, rcon};
    col_next[0] = col[0] ^ temp_word;
    col_next[1] = col[1] ^ col_next[0];
    col_next[2] = col[2] ^ col_next[1];
    col_next[3] = col[3] ^ col_next[2];
  end

  // transposed rows: byte c of row n is byte n of column c
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      row[n] = {col[3][8*n +: 8], col[2][8*n +: 8], col[1][8*n +: 8], col[0][8*n +: 8]};
    end
  end

  // result view of the round key register
  always_comb begin
    out_item.round_index = round;
    out_item.word_zero   = layout_mode ? row[0] : col[0];
    out_item.word_one    = layout_mode ? row[1] : col[1];
    out_item.word_two    = layout_mode ? row[2] : col[2];
    out_item.word_three  = layout_mode ? row[3] : col[3];
    out_item.last_round  = (round == aes128_kx_pkg::LAST_ROUND);
  end

  // layout register
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      layout_mode <= cfg_wr_data;
    end
  end

  // sequencer and round key register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= 4'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state  <= ST_RUN;
            round  <= 4'd0;
            rcon   <= aes128_kx_pkg::RCON_INIT;
            col[0] <= in_item.key_low[31:0];
            col[1] <= in_item.key_low[63:32];
            col[2] <= in_item.key_high[31:0];
            col[3] <= in_item.key_high[63:32];
          end
        end
        ST_RUN: begin
          if (out_fire) begin
            if (round == aes128_kx_pkg::LAST_ROUND) begin
              state <= ST_IDLE;
            end else begin
              round  <= round + 4'd1;
              rcon   <= aes128_kx_pkg::xtime(rcon);
              col[0] <= col_next[0];
              col[1] <= col_next[1];
              col[2] <= col_next[2];
              col[3] <= col_next[3];
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a new key always starts at round 0
  a_start_round: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && (out_item.round_index == 4'd0))
    else $error("key run did not start at round 0");

  // rounds advance by one on each taken result
  a_round_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && !out_item.last_round |=>
      out_valid && (out_item.round_index == $past(out_item.round_index) + 4'd1))
    else $error("round index did not advance by one");

  // taking the last round frees the input side
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_item.last_round |=> in_ready && !out_valid)
    else $error("block not idle after last round");

  // rounds never run past the last one
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.round_index <= aes128_kx_pkg::LAST_ROUND))
    else $error("round index out of range");

endmodule
